@@ sv/itchfc_pkg.sv @@
// Shared types, codes and the message length table for the ITCH framing checker.
package itchfc_pkg;

  // Framing phase, one-hot.
  typedef enum logic [2:0] {
    PH_LEN_HI = 3'b001,
    PH_LEN_LO = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  // Report status codes.
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_LEN = 2'd1;
  localparam logic [1:0] STATUS_MISMATCH = 2'd2;

  // Report kinds.
  localparam logic KIND_MESSAGE = 1'b0;
  localparam logic KIND_END     = 1'b1;

  // Input selector values.
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Body byte positions that carry the stock locate and the timestamp.
  localparam logic [15:0] POS_LOCATE_LAST = 16'd2;
  localparam logic [15:0] POS_STAMP_FIRST = 16'd5;
  localparam logic [15:0] POS_STAMP_LAST  = 16'd10;

  localparam int unsigned OUT_DATA_W = 112;

  typedef struct packed {
    logic        kind;
    logic [7:0]  msg_type;
    logic [15:0] msg_length;
    logic [1:0]  status;
    logic [15:0] locate_code;
    logic [47:0] timestamp_ns;
    logic        time_went_back;
    logic [16:0] leftover_bytes;
  } result_t;

  // Defined body length per message type; unknown types give zero, which never
  // matches since a zero-length message is reported separately.
  function automatic logic [15:0] type_length(input logic [7:0] msg_type);
    logic [15:0] len;
    len = 16'd0;
    case (msg_type)
      8'h53: len = 16'd12; // S
      8'h52: len = 16'd39; // R
      8'h48: len = 16'd25; // H
      8'h59: len = 16'd20; // Y
      8'h4C: len = 16'd26; // L
      8'h56: len = 16'd35; // V
      8'h57: len = 16'd12; // W
      8'h4B: len = 16'd28; // K
      8'h4A: len = 16'd35; // J
      8'h68: len = 16'd21; // h
      8'h41: len = 16'd36; // A
      8'h46: len = 16'd40; // F
      8'h45: len = 16'd31; // E
      8'h43: len = 16'd36; // C
      8'h58: len = 16'd23; // X
      8'h44: len = 16'd19; // D
      8'h55: len = 16'd35; // U
      8'h50: len = 16'd44; // P
      8'h51: len = 16'd40; // Q
      8'h42: len = 16'd19; // B
      8'h49: len = 16'd50; // I
      8'h4E: len = 16'd20; // N
      default: len = 16'd0;
    endcase
    return len;
  endfunction

endpackage

@@ sv/itch_message_framing_checker.sv @@
// Top level of the ITCH 5.0 message framing checker with its output register.
//
// The block takes an ITCH 5.0 file as a byte stream, one beat per byte, and
// splits it into messages framed by a 2-byte big-endian length. After the
// last body byte of a message, or right after a zero length prefix, it emits
// one report beat with the type, the length and a status (ok, zero length, or
// length not equal to the defined length of the type; unknown types always
// mismatch). Ok reports also carry the stock locate, the 48-bit timestamp and
// a flag that is set when that timestamp is below the previous ok one; other
// reports leave those fields zero. An end-of-stream beat (s_tuser high) gives
// a report with m_tuser high and the count of bytes of the unfinished message,
// and framing restarts with the next length prefix. The block takes one input
// beat per clock; a report appears on the output in the cycle after the beat
// that completes it. Every input beat causes at most one report, so the only
// thing that holds the input back is a report left waiting in the output
// register while m_tready is low.
module itch_message_framing_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // [7:0] data_byte
  input  logic         s_tuser,   // [0] op: 0 data byte, 1 end of stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata,   // [7:0] msg_type, [23:8] msg_length,
                                  // [25:24] status, [41:26] locate_code,
                                  // [89:42] timestamp_ns, [90] time_went_back,
                                  // [107:91] leftover_bytes, [111:108] zero
  output logic         m_tuser    // [0] kind: 0 message report, 1 end of stream
);

  logic                in_fire;
  logic                res_valid;
  itchfc_pkg::result_t res;

  // The output register can take a new report when empty or when its current
  // report leaves in this cycle.
  assign s_tready = !m_tvalid || m_tready;
  assign in_fire  = s_tvalid && s_tready;

  itchfc_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .op        (s_tuser),
    .data_byte (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_fire && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res_valid) begin
      m_tuser <= res.kind;
      m_tdata <= {4'b0000, res.leftover_bytes, res.time_went_back, res.timestamp_ns,
                  res.locate_code, res.status, res.msg_length, res.msg_type};
    end
  end

endmodule

@@ sv/itchfc_framer.sv @@
// Per-byte framing state and report generation for the ITCH framing checker.
module itchfc_framer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_fire,
  input  logic                 op,
  input  logic [7:0]           data_byte,
  output logic                 res_valid,
  output itchfc_pkg::result_t  res
);

  itchfc_pkg::phase_t phase, phase_next;
  logic [15:0] length_held, length_held_next;
  logic [15:0] body_position, body_position_next;
  logic [7:0]  type_held, type_held_next;
  logic [15:0] locate_held, locate_held_next;
  logic [47:0] stamp_held, stamp_held_next;
  logic [47:0] last_good_stamp, last_good_stamp_next;

  logic [15:0] len_full;
  logic [7:0]  type_cur;
  logic [15:0] locate_cur;
  logic [47:0] stamp_cur;
  logic [16:0] pos_plus_one;
  logic        body_more;

  // Body fields as they stand after the current byte.
  assign type_cur   = (body_position == 16'd0) ? data_byte : type_held;
  assign locate_cur = (body_position != 16'd0 && body_position <= itchfc_pkg::POS_LOCATE_LAST)
                      ? {locate_held[7:0], data_byte} : locate_held;
  assign stamp_cur  = (body_position >= itchfc_pkg::POS_STAMP_FIRST &&
                       body_position <= itchfc_pkg::POS_STAMP_LAST)
                      ? {stamp_held[39:0], data_byte} : stamp_held;
  assign pos_plus_one = {1'b0, body_position} + 17'd1;
  assign body_more    = pos_plus_one < {1'b0, length_held};
  assign len_full     = {length_held[15:8], data_byte};

  always_comb begin
    phase_next           = phase;
    length_held_next     = length_held;
    body_position_next   = body_position;
    type_held_next       = type_held;
    locate_held_next     = locate_held;
    stamp_held_next      = stamp_held;
    last_good_stamp_next = last_good_stamp;
    res_valid            = 1'b0;
    res                  = '0;

    if (op == itchfc_pkg::OP_END) begin
      res_valid = 1'b1;
      res.kind  = itchfc_pkg::KIND_END;
      case (phase)
        itchfc_pkg::PH_LEN_LO: res.leftover_bytes = 17'd1;
        itchfc_pkg::PH_BODY:   res.leftover_bytes = {1'b0, body_position} + 17'd2;
        default:               res.leftover_bytes = 17'd0;
      endcase
      phase_next = itchfc_pkg::PH_LEN_HI;
    end else begin
      case (phase)
        itchfc_pkg::PH_LEN_HI: begin
          length_held_next = {data_byte, 8'h00};
          phase_next       = itchfc_pkg::PH_LEN_LO;
        end
        itchfc_pkg::PH_LEN_LO: begin
          if (len_full == 16'd0) begin
            res_valid  = 1'b1;
            res.kind   = itchfc_pkg::KIND_MESSAGE;
            res.status = itchfc_pkg::STATUS_ZERO_LEN;
            phase_next = itchfc_pkg::PH_LEN_HI;
          end else begin
            length_held_next   = len_full;
            body_position_next = 16'd0;
            locate_held_next   = 16'd0;
            stamp_held_next    = 48'd0;
            phase_next         = itchfc_pkg::PH_BODY;
          end
        end
        itchfc_pkg::PH_BODY: begin
          type_held_next   = type_cur;
          locate_held_next = locate_cur;
          stamp_held_next  = stamp_cur;
          if (body_more) begin
            body_position_next = pos_plus_one[15:0];
          end else begin
            res_valid      = 1'b1;
            res.kind       = itchfc_pkg::KIND_MESSAGE;
            res.msg_type   = type_cur;
            res.msg_length = length_held;
            phase_next     = itchfc_pkg::PH_LEN_HI;
            if (itchfc_pkg::type_length(type_cur) == length_held) begin
              res.status           = itchfc_pkg::STATUS_OK;
              res.locate_code      = locate_cur;
              res.timestamp_ns     = stamp_cur;
              res.time_went_back   = stamp_cur < last_good_stamp;
              last_good_stamp_next = stamp_cur;
            end else begin
              res.status = itchfc_pkg::STATUS_MISMATCH;
            end
          end
        end
        default: begin
          phase_next = itchfc_pkg::PH_LEN_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= itchfc_pkg::PH_LEN_HI;
      last_good_stamp <= 48'd0;
    end else if (in_fire) begin
      phase           <= phase_next;
      last_good_stamp <= last_good_stamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      length_held   <= length_held_next;
      body_position <= body_position_next;
      type_held     <= type_held_next;
      locate_held   <= locate_held_next;
      stamp_held    <= stamp_held_next;
    end
  end

endmodule

@@ sv/itchfc_checker.sv @@
// Port-level assertions for the ITCH framing checker and their binding.
module itchfc_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [7:0]   s_tdata,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic         m_tuser
);

  // A stalled report holds its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled report changed");

  // An empty output register never holds back the input.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // Every accepted end-of-stream beat gives an end-of-stream report next cycle.
  a_end: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser && s_tdata == s_tdata |=> m_tvalid && m_tuser)
    else $error("missing end-of-stream report");

  // End-of-stream reports carry only the leftover count.
  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[90:0] == 91'd0)
    else $error("end-of-stream report has message fields");

  // Reports that are not ok carry no locate, timestamp or leftover count.
  a_bad_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser && m_tdata[25:24] != 2'd0 |-> m_tdata[111:26] == 86'd0)
    else $error("non-ok report has payload fields");

endmodule

bind itch_message_framing_checker itchfc_checker u_itchfc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

@@ tb/itch_message_framing_checker_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ITCH 5.0 message framing checker.
module itch_message_framing_checker_test;

  localparam int NUM_MSG_TYPES = 22;

  // Stream side: one beat per raw file byte, s_tuser marks end of stream.
  logic         clk = 1'b0;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [7:0]   s_tdata;   // [7:0] data_byte
  logic         s_tuser;   // [0] op
  // Report side.
  logic         m_tvalid;
  logic         m_tready;
  logic [111:0] m_tdata;   // [7:0] msg_type, [23:8] msg_length, [25:24] status,
                           // [41:26] locate_code, [89:42] timestamp_ns,
                           // [90] time_went_back, [107:91] leftover_bytes
  logic         m_tuser;   // [0] kind

  // Expected framing state, advanced once per accepted input beat.
  itchfc_pkg::phase_t fr_phase = itchfc_pkg::PH_LEN_HI;
  logic [15:0] fr_len = '0;
  logic [15:0] fr_pos = '0;
  logic [7:0]  fr_type = '0;
  logic [15:0] fr_locate = '0;
  logic [47:0] fr_stamp = '0;
  logic [47:0] last_ok_stamp = '0;

  // Reports the block still owes us, oldest first.
  itchfc_pkg::result_t reports_due[$];

  int  mismatch_count = 0;
  int  beats_sent = 0;
  int  rx_wait = 0;         // stall drawn after each report beat
  int  rx_hold_cycles = 0;  // long hold-off requested by the backpressure test
  bit  tx_gaps_on = 1'b1;
  bit  rx_gaps_on = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  itch_message_framing_checker u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // The ITCH 5.0 message types and the body length each one must have.
  function automatic void type_entry(input int idx, output logic [7:0] code,
                                     output logic [15:0] len);
    case (idx)
      0:  begin code = "S"; len = 16'd12; end
      1:  begin code = "R"; len = 16'd39; end
      2:  begin code = "H"; len = 16'd25; end
      3:  begin code = "Y"; len = 16'd20; end
      4:  begin code = "L"; len = 16'd26; end
      5:  begin code = "V"; len = 16'd35; end
      6:  begin code = "W"; len = 16'd12; end
      7:  begin code = "K"; len = 16'd28; end
      8:  begin code = "J"; len = 16'd35; end
      9:  begin code = "h"; len = 16'd21; end
      10: begin code = "A"; len = 16'd36; end
      11: begin code = "F"; len = 16'd40; end
      12: begin code = "E"; len = 16'd31; end
      13: begin code = "C"; len = 16'd36; end
      14: begin code = "X"; len = 16'd23; end
      15: begin code = "D"; len = 16'd19; end
      16: begin code = "U"; len = 16'd35; end
      17: begin code = "P"; len = 16'd44; end
      18: begin code = "Q"; len = 16'd40; end
      19: begin code = "B"; len = 16'd19; end
      20: begin code = "I"; len = 16'd50; end
      default: begin code = "N"; len = 16'd20; end
    endcase
  endfunction

  // Zero for an unknown type, so it can never match a nonzero length.
  function automatic logic [15:0] defined_body_len(input logic [7:0] t);
    logic [7:0]  code;
    logic [15:0] len;
    for (int i = 0; i < NUM_MSG_TYPES; i++) begin
      type_entry(i, code, len);
      if (code == t) return len;
    end
    return 16'd0;
  endfunction

  function automatic void clear_frame_state();
    fr_phase  = itchfc_pkg::PH_LEN_HI;
    fr_len    = '0;
    fr_pos    = '0;
    fr_type   = '0;
    fr_locate = '0;
    fr_stamp  = '0;
  endfunction

  // Appends one expected report at the young end of the queue.
  function automatic void add_due(input itchfc_pkg::result_t r);
    reports_due = {reports_due, r};
  endfunction

  // Advances the expected framing by one accepted beat and queues the report
  // that the beat completes, if any.
  function automatic void predict_framing(input logic op, input logic [7:0] b);
    itchfc_pkg::result_t r;
    r = '0;
    if (op == itchfc_pkg::OP_END) begin
      // The partial message is dropped; the last ok timestamp survives.
      r.kind = itchfc_pkg::KIND_END;
      case (fr_phase)
        itchfc_pkg::PH_LEN_LO: r.leftover_bytes = 17'd1;
        itchfc_pkg::PH_BODY:   r.leftover_bytes = 17'd2 + {1'b0, fr_pos};
        default:               r.leftover_bytes = 17'd0;
      endcase
      add_due(r);
      clear_frame_state();
      return;
    end
    case (fr_phase)
      itchfc_pkg::PH_LEN_HI: begin
        fr_len   = {b, 8'h00};
        fr_phase = itchfc_pkg::PH_LEN_LO;
      end
      itchfc_pkg::PH_LEN_LO: begin
        fr_len[7:0] = b;
        if (fr_len == 16'd0) begin
          // A zero length prefix is reported at once; no body follows.
          r.kind   = itchfc_pkg::KIND_MESSAGE;
          r.status = itchfc_pkg::STATUS_ZERO_LEN;
          add_due(r);
          clear_frame_state();
        end else begin
          fr_pos   = '0;
          fr_phase = itchfc_pkg::PH_BODY;
        end
      end
      default: begin
        if (fr_pos == 16'd0) fr_type = b;
        else if (fr_pos <= itchfc_pkg::POS_LOCATE_LAST) fr_locate = {fr_locate[7:0], b};
        else if (fr_pos >= itchfc_pkg::POS_STAMP_FIRST && fr_pos <= itchfc_pkg::POS_STAMP_LAST)
          fr_stamp = {fr_stamp[39:0], b};
        if (int'(fr_pos) + 1 < int'(fr_len)) begin
          fr_pos = fr_pos + 16'd1;
        end else begin
          r.kind       = itchfc_pkg::KIND_MESSAGE;
          r.msg_type   = fr_type;
          r.msg_length = fr_len;
          if (defined_body_len(fr_type) != fr_len) begin
            r.status = itchfc_pkg::STATUS_MISMATCH;
          end else begin
            // Ok messages always replace the last ok timestamp, even when
            // they went back in time.
            r.status         = itchfc_pkg::STATUS_OK;
            r.locate_code    = fr_locate;
            r.timestamp_ns   = fr_stamp;
            r.time_went_back = (fr_stamp < last_ok_stamp);
            last_ok_stamp    = fr_stamp;
          end
          add_due(r);
          clear_frame_state();
        end
      end
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got, inout bit bad);
    if (want !== got) begin
      bad = 1'b1;
      if (mismatch_count < 10)
        $display("%0t: report field %s: expected %0h, got %0h", $realtime, name, want, got);
    end
  endfunction

  // Report checker: every report beat is compared with the oldest expectation.
  always @(posedge clk) begin : report_check
    itchfc_pkg::result_t want;
    itchfc_pkg::result_t seen;
    bit                  bad;
    if (!rst && m_tvalid && m_tready) begin
      seen.kind           = m_tuser;
      seen.msg_type       = m_tdata[7:0];
      seen.msg_length     = m_tdata[23:8];
      seen.status         = m_tdata[25:24];
      seen.locate_code    = m_tdata[41:26];
      seen.timestamp_ns   = m_tdata[89:42];
      seen.time_went_back = m_tdata[90];
      seen.leftover_bytes = m_tdata[107:91];
      rx_wait = rx_gaps_on ? $urandom_range(0, 15) : 0;
      if (reports_due.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: report beat with nothing expected: %p", $realtime, seen);
        mismatch_count++;
      end else begin
        want = reports_due.pop_front();
        bad  = 1'b0;
        compare_field("kind", 64'(want.kind), 64'(seen.kind), bad);
        compare_field("msg_type", 64'(want.msg_type), 64'(seen.msg_type), bad);
        compare_field("msg_length", 64'(want.msg_length), 64'(seen.msg_length), bad);
        compare_field("status", 64'(want.status), 64'(seen.status), bad);
        compare_field("locate_code", 64'(want.locate_code), 64'(seen.locate_code), bad);
        compare_field("timestamp_ns", 64'(want.timestamp_ns), 64'(seen.timestamp_ns), bad);
        compare_field("time_went_back", 64'(want.time_went_back),
                      64'(seen.time_went_back), bad);
        compare_field("leftover_bytes", 64'(want.leftover_bytes),
                      64'(seen.leftover_bytes), bad);
        compare_field("padding", 64'd0, 64'(m_tdata[111:108]), bad);
        if (bad) mismatch_count++;
      end
    end
  end

  // Report receiver. It stalls for the drawn number of cycles after each
  // report beat, and for the whole hold-off when one is requested.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        m_tready = 1'b0;
        rx_hold_cycles--;
      end else if (rx_wait > 0) begin
        m_tready = 1'b0;
        rx_wait--;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Offers one stream beat after an optional gap and waits until it is taken.
  // Called and returns at a falling edge.
  task automatic send_beat(input logic op, input logic [7:0] b);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 15) : 0;
    repeat (gap) @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = b;
    forever begin
      @(posedge clk);
      if (s_tready === 1'b1) break;
    end
    predict_framing(op, b);
    beats_sent++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  // Sends a length prefix and the first body_count body bytes. The type,
  // locate and timestamp land at their ITCH positions; other bytes are random.
  task automatic send_frame(input logic [7:0] mtype, input logic [15:0] mlen,
                            input logic [15:0] loc, input logic [47:0] stamp,
                            input int body_count);
    logic [7:0] b;
    send_beat(itchfc_pkg::OP_DATA, mlen[15:8]);
    send_beat(itchfc_pkg::OP_DATA, mlen[7:0]);
    for (int i = 0; i < body_count; i++) begin
      b = 8'($urandom_range(0, 255));
      if (i == 0) b = mtype;
      else if (i == 1) b = loc[15:8];
      else if (i == 2) b = loc[7:0];
      else if (i >= 5 && i <= 10) b = stamp[8 * (10 - i) +: 8];
      send_beat(itchfc_pkg::OP_DATA, b);
    end
  endtask

  task automatic wait_reports_drained();
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  // End of stream while idle, after a lone length high byte, and inside a body.
  task automatic test_end_of_stream();
    send_beat(itchfc_pkg::OP_END, 8'hFF);
    send_beat(itchfc_pkg::OP_DATA, 8'h00);
    send_beat(itchfc_pkg::OP_END, 8'h00);
    send_frame("S", 16'd12, 16'h1234, 48'h0000_0000_0001, 3);
    send_beat(itchfc_pkg::OP_END, 8'hA5);
  endtask

  task automatic test_zero_length();
    send_frame(8'h00, 16'd0, 16'h0000, 48'h0, 0);
  endtask

  // All-ones locate and timestamp, then an ok message whose zero timestamp
  // goes back in time.
  task automatic test_field_extremes();
    send_frame("S", 16'd12, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 12);
    send_frame("W", 16'd12, 16'h0000, 48'h0000_0000_0000, 12);
  endtask

  // Known type with the wrong length, unknown types, one-byte bodies.
  task automatic test_length_mismatch();
    send_frame("S", 16'd13, 16'hBEEF, 48'h0000_0000_0005, 13);
    send_frame(8'h00, 16'd1, 16'h0, 48'h0, 1);
    send_frame(8'hFF, 16'd2, 16'h0, 48'h0, 2);
    send_frame("I", 16'd1, 16'h0, 48'h0, 1);
  endtask

  // The largest length prefix, cut off early by an end of stream, and a whole
  // message whose length needs both prefix bytes.
  task automatic test_longest_frames();
    tx_gaps_on = 1'b0;
    send_frame(8'hFF, 16'hFFFF, 16'($urandom_range(0, 65535)),
               48'({$urandom, $urandom}), 20);
    send_beat(itchfc_pkg::OP_END, 8'h00);
    send_frame("A", 16'h0100, 16'($urandom_range(0, 65535)),
               48'({$urandom, $urandom}), 256);
    tx_gaps_on = 1'b1;
  endtask

  // The receiver holds off for a long stretch while zero-length messages keep
  // coming back to back, so the output register fills and the input stalls.
  task automatic test_output_backpressure();
    wait_reports_drained();
    tx_gaps_on = 1'b0;
    @(posedge clk);
    rx_hold_cycles = 300;
    @(negedge clk);
    repeat (40) send_frame(8'h00, 16'd0, 16'h0, 48'h0, 0);
    wait_reports_drained();
    tx_gaps_on = 1'b1;
  endtask

  // Mostly well-formed messages of every type with random content, mixed
  // with wrong lengths, unknown types, zero lengths and cut-off streams.
  task automatic test_random_stream();
    int          first_beat;
    int          frames;
    int          pick;
    int          body;
    logic [7:0]  t;
    logic [15:0] len;
    logic [15:0] loc;
    logic [47:0] stamp;
    logic [47:0] stamp_trail;
    first_beat  = beats_sent;
    frames      = 0;
    stamp_trail = 48'd1_000_000;
    while (beats_sent - first_beat < 620) begin
      if ($urandom_range(0, 7) == 0) tx_gaps_on = !tx_gaps_on;
      if ($urandom_range(0, 7) == 0) rx_gaps_on = !rx_gaps_on;
      // Now and then the sender waits for every outstanding report.
      if (frames % 60 == 59) wait_reports_drained();
      type_entry($urandom_range(0, NUM_MSG_TYPES - 1), t, len);
      loc = 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 2))
        0:       stamp = 48'({$urandom, $urandom});
        1:       stamp = stamp_trail + $urandom_range(0, 5000);
        default: stamp = stamp_trail - $urandom_range(1, 5000);
      endcase
      stamp_trail = stamp;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        send_frame(t, len, loc, stamp, len);
      end else if (pick < 75) begin
        len = 16'($urandom_range(1, 60));
        send_frame(t, len, loc, stamp, len);
      end else if (pick < 83) begin
        len = 16'($urandom_range(1, 60));
        send_frame(8'($urandom_range(0, 255)), len, loc, stamp, len);
      end else if (pick < 88) begin
        send_frame(8'h00, 16'd0, 16'h0, 48'h0, 0);
      end else if (pick < 94) begin
        body = $urandom_range(0, len - 1);
        send_frame(t, len, loc, stamp, body);
        send_beat(itchfc_pkg::OP_END, 8'($urandom_range(0, 255)));
      end else if (pick < 97) begin
        send_beat(itchfc_pkg::OP_DATA, 8'($urandom_range(0, 255)));
        send_beat(itchfc_pkg::OP_END, 8'($urandom_range(0, 255)));
      end else begin
        send_beat(itchfc_pkg::OP_END, 8'($urandom_range(0, 255)));
      end
      frames++;
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = 8'h00;
    s_tuser  = itchfc_pkg::OP_DATA;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_end_of_stream();
    test_zero_length();
    test_field_extremes();
    test_length_mismatch();
    test_longest_frames();
    test_output_backpressure();
    test_random_stream();

    // Let any stray report show up before the verdict.
    wait_reports_drained();
    repeat (20) @(posedge clk);
    if (reports_due.size() != 0) mismatch_count++;
    if (mismatch_count == 0) begin
      $display("itch_message_framing_checker_test: done, clean");
    end else begin
      $display("itch_message_framing_checker_test: done, errors");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #4_000_000;
    $display("itch_message_framing_checker_test: done, errors");
    $finish;
  end

endmodule

@@ files.f @@
sv/itchfc_pkg.sv
sv/itchfc_framer.sv
sv/itch_message_framing_checker.sv
sv/itchfc_checker.sv
tb/itch_message_framing_checker_test.sv
